// File: rtl/core/chs_pkg.sv
// Shared types, codes and constants of the chained hash set.
package chs_pkg;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int NUM_NODES_DEF   = 64;

  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int BUCKET_W  = 4;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;
  localparam int DIG_BITS  = 4;   // key bits folded into the remainder per cycle

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_BUCKET,
    S_LINK,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    mod_step;
    logic    clr_wr;
    logic    bkt_rd;
    logic    ins_wr;
    logic    link_wr;
    logic    used_inc;
    logic    node_rd_head;
    logic    node_rd_next;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic is_search;
    logic head_valid;
    logic pool_full;
    logic key_match;
    logic next_valid;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/chs_ctrl.sv
// Controller state machine of the chained hash set.
module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd
);
  import chs_pkg::*;

  state_t  state, state_next;
  status_t status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.bkt_rd = 1'b1;
        state_next = S_BUCKET;
      end
      S_BUCKET: begin
        if (!sts.is_search) begin
          if (sts.pool_full) begin
            status_next = ST_POOL_FULL;
            state_next  = S_DONE;
          end else begin
            cmd.ins_wr = 1'b1;
            if (sts.head_valid) begin
              state_next = S_LINK;
            end else begin
              cmd.used_inc = 1'b1;
              status_next  = ST_INSERTED;
              state_next   = S_DONE;
            end
          end
        end else if (sts.head_valid) begin
          cmd.node_rd_head = 1'b1;
          state_next       = S_WALK;
        end else begin
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end
      end
      S_LINK: begin
        cmd.link_wr  = 1'b1;
        cmd.used_inc = 1'b1;
        status_next  = ST_INSERTED;
        state_next   = S_DONE;
      end
      S_WALK: begin
        if (sts.key_match) begin
          status_next = ST_FOUND;
          state_next  = S_DONE;
        end else if (sts.next_valid) begin
          cmd.node_rd_next = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        cmd.res_status = status;
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/core/chs_dp.sv
// Datapath of the chained hash set: remainder unit, bucket and node memories, result register.
module chs_dp #(
  parameter int NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF,
  parameter int NUM_NODES   = chs_pkg::NUM_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chs_pkg::cmd_t                 cmd,
  output chs_pkg::sts_t                 sts,
  input  logic                          in_action,
  input  logic [chs_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output chs_pkg::status_t              out_status,
  output logic [chs_pkg::BUCKET_W-1:0]  out_bucket
);
  import chs_pkg::*;

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int NW    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int CW    = $clog2(NUM_NODES + 1);
  localparam int STEPS = KEY_W / DIG_BITS;
  localparam int SW    = $clog2(STEPS);
  localparam int BKW   = 2 * NW + 1;   // {head valid, head, tail}
  localparam int NXW   = NW + 1;       // {next valid, next}
  localparam logic [BW:0] NB = NUM_BUCKETS[BW:0];

  logic              action;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  sh;
  logic [BW-1:0]     rem, rem_next;
  logic [SW-1:0]     step;
  logic [BW-1:0]     clr_cnt;
  logic [CW-1:0]     used;
  logic [BKW-1:0]    bkt_q;
  logic [KEY_W-1:0]  key_q;
  logic [NXW-1:0]    nxt_q;

  logic [BKW-1:0]    bkt_mem [NUM_BUCKETS];
  logic [KEY_W-1:0]  key_mem [NUM_NODES];
  logic [NXW-1:0]    next_mem [NUM_NODES];

  logic              hv;
  logic [NW-1:0]     head, tail, n_idx, node_addr;
  logic [BW-1:0]     bkt_waddr;
  logic [BKW-1:0]    bkt_wdata;
  logic [NW-1:0]     nxt_waddr;
  logic [NXW-1:0]    nxt_wdata;

  assign hv    = bkt_q[2*NW];
  assign head  = bkt_q[2*NW-1:NW];
  assign tail  = bkt_q[NW-1:0];
  assign n_idx = used[NW-1:0];

  // Remainder: fold DIG_BITS key bits per cycle, one compare-subtract per bit.
  always_comb begin
    logic [BW:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < DIG_BITS; i++) begin
      t = {t[BW-1:0], sh[KEY_W-1-i]};
      if (t >= NB) begin
        t = t - NB;
      end
    end
    rem_next = t[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action <= in_action;
      key    <= in_key;
      sh     <= in_key;
      rem    <= '0;
      step   <= '0;
    end else if (cmd.mod_step) begin
      rem  <= rem_next;
      sh   <= sh << DIG_BITS;
      step <= step + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      used    <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + BW'(1);
      end
      if (cmd.used_inc) begin
        used <= used + CW'(1);
      end
    end
  end

  // Bucket memory: one write port shared by the clearing pass and inserts.
  always_comb begin
    bkt_waddr = cmd.clr_wr ? clr_cnt : rem;
    bkt_wdata = cmd.clr_wr ? '0 : {1'b1, (hv ? head : n_idx), n_idx};
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.ins_wr) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (cmd.bkt_rd) begin
      bkt_q <= bkt_mem[rem];
    end
  end

  // Node memories: a new node is written with no successor, then the old tail is linked.
  assign node_addr = cmd.node_rd_next ? nxt_q[NW-1:0] : head;
  assign nxt_waddr = cmd.link_wr ? tail : n_idx;
  assign nxt_wdata = cmd.link_wr ? {1'b1, n_idx} : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[n_idx] <= key;
    end
    if (cmd.ins_wr || cmd.link_wr) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    if (cmd.node_rd_head || cmd.node_rd_next) begin
      key_q <= key_mem[node_addr];
      nxt_q <= next_mem[node_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_bucket <= BUCKET_W'(rem);
    end
  end

  always_comb begin
    sts.clr_done   = (clr_cnt == BW'(NUM_BUCKETS - 1));
    sts.mod_done   = (step == SW'(STEPS - 1));
    sts.is_search  = (action == ACT_SEARCH);
    sts.head_valid = hv;
    sts.pool_full  = (used == CW'(NUM_NODES));
    sts.key_match  = (key_q == key);
    sts.next_valid = nxt_q[NW];
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// File: rtl/core/chained_hash_set_core.sv
// Top level of the chained hash set: controller and datapath.
//
//   channel  dir  tdata                   tuser
//   s_*      in   [31:0] key              [0] action (0 insert, 1 search)
//   m_*      out  [3:0] bucket, [7:4] 0   [1:0] status (0 ins, 1 found, 2 miss, 3 full)
//
// Items are handled one at a time. An insert passes through remainder folding, the
// bucket read, the memory writes and the result load; a search passes through folding
// and the bucket read, then reads chain nodes one after another through the single
// node-memory read port. After reset a clearing pass empties the bucket memory before
// s_tready rises. A stalled result waits in the output register while the next key is
// already taken in.
module chained_hash_set_core #(
  parameter int NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF,
  parameter int NUM_NODES   = chs_pkg::NUM_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [chs_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] key
  input  logic                           s_tuser,   // [0] action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [chs_pkg::M_TDATA_W-1:0]  m_tdata,   // [3:0] bucket, rest zero
  output logic [chs_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
  import chs_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  status_t             out_status;
  logic [BUCKET_W-1:0] out_bucket;

  // Sequence each item: hash, bucket read, then insert writes or a chain walk.
  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the memories, node pool count and the result register.
  chs_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_NODES   (NUM_NODES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_tuser),
    .in_key     (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_bucket (out_bucket)
  );

  // Pad the bucket index up to a whole byte.
  assign m_tdata = {{(M_TDATA_W - BUCKET_W){1'b0}}, out_bucket};
  assign m_tuser = out_status;

endmodule
